// ===== src/swm_pkg.sv =====
// Package for the sliding-window median filter.
// Holds the sizes, the controller state type and the cell link and control structs.
// No dependencies.
`default_nettype none

package swm_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int DATA_W      = 32;
    localparam int OUT_W       = DATA_W + 1;
    localparam int CFG_W       = 7;
    localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int SAT_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int RESET_WSIZE = (MAX_WINDOW < 3) ? MAX_WINDOW : 3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_MED  = 3'b100
    } t_state;

    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic                     ev;
        logic signed [DATA_W-1:0] value;
    } t_link;

    typedef struct packed {
        logic                     load;
        logic                     clear;
        logic                     flush;
        logic                     evict;
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] old;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== src/sliding_window_median_top.sv =====
// Top level of the sliding-window median filter: controller, arrival ring, cell row.
// Depends on swm_pkg, swm_cell and swm_ring.
//
// channel   direction  handshake                payload
// in        input      i_in_valid / o_in_stall  i_sample, i_start_req
// out       output     o_out_valid / i_out_stall o_median_times_two
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_window_size
//
// A sample that yields a median passes accept with ring read, one parallel cell-row
// update, and median select and add into the output register; a sample that
// leaves the window short of full skips the median step. A stalled output holds
// the controller in the median step. Reset is synchronous; the row comes up empty
// and window_size is 3. No clearing pass: the cell valid bits clear directly on reset.
`default_nettype none

module sliding_window_median_top
    import swm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [DATA_W-1:0] i_sample,
    input  wire logic                     i_start_req,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [OUT_W-1:0]       o_median_times_two,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_W-1:0]         i_cfg_window_size
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_wsize, n_wsize;
    logic [CNT_W-1:0]         r_fill, n_fill;
    logic [IDX_W-1:0]         r_ptr, n_ptr;
    logic signed [DATA_W-1:0] r_sample, n_sample;
    logic                     r_start, n_start;
    logic                     r_out_valid, n_out_valid;
    logic signed [OUT_W-1:0]  r_out, n_out;

    logic                     w_in_acc;
    logic                     w_cfg_acc;
    logic [SAT_W-1:0]         w_cfg_ext;
    logic [CNT_W-1:0]         w_fill_eff;
    logic                     w_full;
    logic                     w_emit;
    logic                     w_out_free;
    logic signed [DATA_W-1:0] w_old;
    logic [IDX_W-1:0]         w_waddr;
    t_cell_ctl                w_ctl;
    logic [IDX_W-1:0]         w_mid;
    logic [IDX_W-1:0]         w_lo_idx;

    t_link                    w_link  [MAX_WINDOW];
    logic signed [DATA_W-1:0] w_value [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]    w_valid;

    localparam t_link LINK_LO = '{valid: 1'b1, gt: 1'b0, ev: 1'b0, value: '0};
    localparam t_link LINK_HI = '{valid: 1'b0, gt: 1'b1, ev: 1'b0, value: '0};

    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_cfg_acc  = i_cfg_valid & o_cfg_ready;
    assign w_cfg_ext  = SAT_W'(i_cfg_window_size);
    assign w_fill_eff = r_start ? '0 : r_fill;
    assign w_full     = (w_fill_eff == r_wsize);
    assign w_emit     = w_full | ((w_fill_eff + CNT_W'(1)) == r_wsize);
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_waddr    = w_full ? r_ptr : w_fill_eff[IDX_W-1:0];
    assign w_mid      = IDX_W'(r_wsize >> 1);
    assign w_lo_idx   = r_wsize[0] ? w_mid : w_mid - IDX_W'(1);

    always_comb begin
        w_ctl.load   = (r_state == ST_EXEC);
        w_ctl.clear  = w_cfg_acc;
        w_ctl.flush  = r_start;
        w_ctl.evict  = w_full;
        w_ctl.sample = r_sample;
        w_ctl.old    = w_old;
    end

    swm_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_EXEC),
        .i_waddr (w_waddr),
        .i_wdata (r_sample),
        .i_raddr (r_ptr),
        .o_rdata (w_old)
    );

    for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
        t_link w_lo;
        t_link w_hi;
        if (gi == 0) begin : g_first
            assign w_lo = LINK_LO;
        end else begin : g_mid_lo
            assign w_lo = w_link[gi-1];
        end
        if (gi == MAX_WINDOW - 1) begin : g_last
            assign w_hi = LINK_HI;
        end else begin : g_mid_hi
            assign w_hi = w_link[gi+1];
        end
        swm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_lo    (w_lo),
            .i_hi    (w_hi),
            .o_link  (w_link[gi]),
            .o_value (w_value[gi]),
            .o_valid (w_valid[gi])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_wsize     = r_wsize;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_sample    = r_sample;
        n_start     = r_start;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (w_cfg_acc) begin
                    if (w_cfg_ext == '0) begin
                        n_wsize = CNT_W'(1);
                    end else if (w_cfg_ext > SAT_W'(MAX_WINDOW)) begin
                        n_wsize = CNT_W'(MAX_WINDOW);
                    end else begin
                        n_wsize = CNT_W'(w_cfg_ext);
                    end
                    n_fill = '0;
                    n_ptr  = '0;
                end else if (w_in_acc) begin
                    n_sample = i_sample;
                    n_start  = i_start_req;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_full) begin
                    n_fill = w_fill_eff;
                    n_ptr  = ((CNT_W'(r_ptr) + CNT_W'(1)) == r_wsize) ? '0 : r_ptr + IDX_W'(1);
                end else begin
                    n_fill = w_fill_eff + CNT_W'(1);
                    n_ptr  = r_start ? '0 : r_ptr;
                end
                n_state = w_emit ? ST_MED : ST_IDLE;
            end
            ST_MED: begin
                if (w_out_free) begin
                    n_out = OUT_W'(w_value[w_lo_idx]) + OUT_W'(w_value[w_mid]);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wsize     <= CNT_W'(RESET_WSIZE);
            r_fill      <= '0;
            r_ptr       <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wsize     <= n_wsize;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_out    <= n_out;
    end

    assign o_in_stall         = (r_state != ST_IDLE) | i_cfg_valid;
    assign o_cfg_ready        = (r_state == ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_median_times_two = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_wsize)
        else $error("fill count above window size");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_ptr) < r_wsize)
        else $error("oldest pointer outside window");

    a_row_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(w_valid) == int'(r_fill)))
        else $error("cell row occupancy differs from fill count");

endmodule

`default_nettype wire

// ===== src/swm_cell.sv =====
// One cell of the sorted row: holds one sample and its valid bit.
// Removes the evicted sample and inserts the new one using its two neighbors.
// Depends on swm_pkg.
`default_nettype none

module swm_cell
    import swm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cell_ctl                i_ctl,
    input  wire t_link                    i_lo,
    input  wire t_link                    i_hi,
    output t_link                         o_link,
    output logic signed [DATA_W-1:0]      o_value,
    output logic                          o_valid
);

    logic signed [DATA_W-1:0] r_value, n_value;
    logic                     r_valid, n_valid;
    t_link                    w_cur;
    t_link                    w_prev;
    logic                     w_prev_g;
    logic                     w_cur_g;

    always_comb begin
        o_link.valid = r_valid & ~i_ctl.flush;
        o_link.gt    = r_value > i_ctl.sample;
        o_link.ev    = i_ctl.evict & r_valid & ~i_ctl.flush & (r_value >= i_ctl.old);
        o_link.value = r_value;
    end

    always_comb begin
        w_cur  = o_link.ev ? i_hi : o_link;
        w_prev = i_lo.ev ? o_link : i_lo;
        w_prev_g = ~w_prev.valid | w_prev.gt;
        w_cur_g  = ~w_cur.valid | w_cur.gt;
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.load) begin
            if (w_prev_g) begin
                n_value = w_prev.value;
                n_valid = w_prev.valid;
            end else if (w_cur_g) begin
                n_value = i_ctl.sample;
                n_valid = 1'b1;
            end else begin
                n_value = w_cur.value;
                n_valid = w_cur.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== src/swm_ring.sv =====
// Arrival-order ring of the filter: one write port, one registered read port.
// Supplies the oldest sample for eviction.
// Depends on swm_pkg.
`default_nettype none

module swm_ring
    import swm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [IDX_W-1:0]         i_waddr,
    input  wire logic signed [DATA_W-1:0] i_wdata,
    input  wire logic [IDX_W-1:0]         i_raddr,
    output logic signed [DATA_W-1:0]      o_rdata
);

    logic signed [DATA_W-1:0] r_mem [MAX_WINDOW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
